### rtl/core/ssq_pkg.sv
`timescale 1ns / 1ps

package ssq_pkg;

    // Table geometry
    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Field widths
    localparam int WID_W   = 6;
    localparam int REQ_W   = 31;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 4;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // Item kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FAIL      = 2'd1,
        STATUS_EXHAUSTED = 2'd2
    } ssq_status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } ssq_state_t;

    // Slot store read request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } ssq_rd_req_t;

    // Slot store read data, registered: valid in the cycle after the request
    typedef struct packed {
        logic               occ;
        logic               cls;
        logic [STAMP_W-1:0] stamp;
        logic [WID_W-1:0]   wid;
        logic [REQ_W-1:0]   req;
    } ssq_rd_data_t;

    // Slot store write: fill a slot or free it
    typedef struct packed {
        logic               fill;
        logic               free;
        logic [IDX_W-1:0]   addr;
        logic               cls;
        logic [STAMP_W-1:0] stamp;
        logic [WID_W-1:0]   wid;
        logic [REQ_W-1:0]   req;
    } ssq_wr_t;

    // Slot index as carried in the result: low bits, zero extended
    function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

### rtl/core/ssq_chan_if.sv
`timescale 1ns / 1ps

// Command channel: add or take
interface ssq_cmd_if;
    import ssq_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic             reader_class;
    logic [WID_W-1:0] writer_id;
    logic [REQ_W-1:0] request_no;

    modport source (
        output valid, kind, reader_class, writer_id, request_no,
        input  ready
    );
    modport sink (
        input  valid, kind, reader_class, writer_id, request_no,
        output ready
    );
endinterface

// Result channel
interface ssq_res_if;
    import ssq_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [WID_W-1:0]  out_writer_id;
    logic [REQ_W-1:0]  out_request_no;
    logic [SLOT_W-1:0] slot_used;

    modport source (
        output valid, status, out_writer_id, out_request_no, slot_used,
        input  ready
    );
    modport sink (
        input  valid, status, out_writer_id, out_request_no, slot_used,
        output ready
    );
endinterface

### rtl/core/ssq_slot_mem.sv
`timescale 1ns / 1ps

module ssq_slot_mem
    import ssq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ssq_rd_req_t  rd_req,
    output ssq_rd_data_t rd_data,
    input  ssq_wr_t      wr
);

    // Stamp memory holds class bit and stamp; element memory holds writer and request
    logic [STAMP_W:0]       stamp_mem [SLOTS];
    logic [WID_W+REQ_W-1:0] elem_mem  [SLOTS];
    logic [SLOTS-1:0]       occ_reg;

    logic [STAMP_W:0]       stamp_rd_reg;
    logic [WID_W+REQ_W-1:0] elem_rd_reg;
    logic                   occ_rd_reg;

    // Occupancy flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            occ_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr.fill)
                occ_reg[wr.addr] <= 1'b1;
            else if (wr.free)
                occ_reg[wr.addr] <= 1'b0;
            if (rd_req.en)
                occ_rd_reg <= occ_reg[rd_req.addr];
        end
    end

    // Stamp memory
    always_ff @(posedge clk)
    begin
        if (wr.fill)
            stamp_mem[wr.addr] <= {wr.cls, wr.stamp};
        if (rd_req.en)
            stamp_rd_reg <= stamp_mem[rd_req.addr];
    end

    // Element memory
    always_ff @(posedge clk)
    begin
        if (wr.fill)
            elem_mem[wr.addr] <= {wr.wid, wr.req};
        if (rd_req.en)
            elem_rd_reg <= elem_mem[rd_req.addr];
    end

    assign rd_data.occ   = occ_rd_reg;
    assign rd_data.cls   = stamp_rd_reg[STAMP_W];
    assign rd_data.stamp = stamp_rd_reg[STAMP_W-1:0];
    assign rd_data.wid   = elem_rd_reg[WID_W+REQ_W-1:REQ_W];
    assign rd_data.req   = elem_rd_reg[REQ_W-1:0];

endmodule

### rtl/core/ssq_ctrl.sv
`timescale 1ns / 1ps

module ssq_ctrl
    import ssq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ssq_cmd_if.sink       cmd,
    ssq_res_if.source     result,
    output ssq_rd_req_t   rd_req,
    input  ssq_rd_data_t  rd_data,
    output ssq_wr_t       wr
);

    ssq_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;

    logic               kind_reg, kind_next;
    logic               cls_reg, cls_next;
    logic [WID_W-1:0]   wid_reg, wid_next;
    logic [REQ_W-1:0]   req_reg, req_next;

    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_reg, best_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic [WID_W-1:0]   best_wid_reg, best_wid_next;
    logic [REQ_W-1:0]   best_req_reg, best_req_next;

    logic [STAMP_W-1:0] stamp_counter_reg, stamp_counter_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [WID_W-1:0]   out_wid_reg, out_wid_next;
    logic [REQ_W-1:0]   out_req_reg, out_req_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;

    logic               commit;

    // Next state and outputs
    always_comb
    begin
        state_next         = state_reg;
        scan_next          = scan_reg;
        chk_vld_next       = chk_vld_reg;
        chk_idx_next       = chk_idx_reg;
        kind_next          = kind_reg;
        cls_next           = cls_reg;
        wid_next           = wid_reg;
        req_next           = req_reg;
        found_next         = found_reg;
        best_next          = best_reg;
        best_stamp_next    = best_stamp_reg;
        best_wid_next      = best_wid_reg;
        best_req_next      = best_req_reg;
        stamp_counter_next = stamp_counter_reg;
        out_valid_next     = out_valid_reg;
        out_status_next    = out_status_reg;
        out_wid_next       = out_wid_reg;
        out_req_next       = out_req_reg;
        out_slot_next      = out_slot_reg;
        commit             = 1'b0;

        cmd.ready   = (state_reg == ST_IDLE);
        rd_req.en   = 1'b0;
        rd_req.addr = scan_reg;

        wr.fill  = 1'b0;
        wr.free  = 1'b0;
        wr.addr  = best_reg;
        wr.cls   = req_reg[0];
        wr.stamp = stamp_counter_reg + STAMP_W'(1);
        wr.wid   = wid_reg;
        wr.req   = req_reg;

        // Result beat taken
        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        // Evaluate the slot read in the previous cycle
        if (chk_vld_reg)
        begin
            if (kind_reg == KIND_ADD)
            begin
                if (!rd_data.occ && !found_reg)
                begin
                    found_next = 1'b1;
                    best_next  = chk_idx_reg;
                end
            end
            else if (rd_data.occ && (rd_data.cls == cls_reg) &&
                     (!found_reg || (rd_data.stamp < best_stamp_reg)))
            begin
                found_next      = 1'b1;
                best_next       = chk_idx_reg;
                best_stamp_next = rd_data.stamp;
                best_wid_next   = rd_data.wid;
                best_req_next   = rd_data.req;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next  = cmd.kind;
                    cls_next   = cmd.reader_class;
                    wid_next   = cmd.writer_id;
                    req_next   = cmd.request_no;
                    found_next = 1'b0;
                    scan_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_req.en    = 1'b1;
                chk_vld_next = 1'b1;
                chk_idx_next = scan_reg;
                if (scan_reg == LAST_IDX)
                    state_next = ST_LAST;
                else
                    scan_next = scan_reg + IDX_W'(1);
            end
            ST_LAST:
            begin
                chk_vld_next = 1'b0;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    commit          = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_wid_next    = '0;
                    out_req_next    = '0;
                    out_slot_next   = slot_field(best_reg);
                    if (!found_reg)
                    begin
                        out_status_next = STATUS_FAIL;
                        out_slot_next   = '0;
                    end
                    else if (kind_reg == KIND_ADD)
                    begin
                        if (stamp_counter_reg == STAMP_MAX)
                        begin
                            out_status_next = STATUS_EXHAUSTED;
                            out_slot_next   = '0;
                        end
                        else
                        begin
                            wr.fill            = 1'b1;
                            stamp_counter_next = stamp_counter_reg + STAMP_W'(1);
                        end
                    end
                    else
                    begin
                        wr.free      = 1'b1;
                        out_wid_next = best_wid_reg;
                        out_req_next = best_req_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            chk_vld_reg       <= 1'b0;
            found_reg         <= 1'b0;
            stamp_counter_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            chk_vld_reg       <= chk_vld_next;
            found_reg         <= found_next;
            stamp_counter_reg <= stamp_counter_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        chk_idx_reg    <= chk_idx_next;
        kind_reg       <= kind_next;
        cls_reg        <= cls_next;
        wid_reg        <= wid_next;
        req_reg        <= req_next;
        best_reg       <= best_next;
        best_stamp_reg <= best_stamp_next;
        best_wid_reg   <= best_wid_next;
        best_req_reg   <= best_req_next;
        out_status_reg <= out_status_next;
        out_wid_reg    <= out_wid_next;
        out_req_reg    <= out_req_next;
        out_slot_reg   <= out_slot_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = out_status_reg;
    assign result.out_writer_id  = out_wid_reg;
    assign result.out_request_no = out_req_reg;
    assign result.slot_used      = out_slot_reg;

    // A new result only ever comes out of the finish state
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    // Every scan read is evaluated in the following cycle
    a_scan_checked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> chk_vld_reg)
        else $error("scan read not evaluated");

    // The stamp counter moves only on a slot fill, by one
    a_stamp_on_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !wr.fill |=> $stable(stamp_counter_reg))
        else $error("stamp counter moved without a fill");

    a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr.fill |=> (stamp_counter_reg == $past(stamp_counter_reg) + STAMP_W'(1)))
        else $error("stamp counter step wrong");

    // Memory writes only while committing, never both at once
    a_write_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.fill || wr.free) |-> (commit && !(wr.fill && wr.free)))
        else $error("slot write outside commit");

endmodule

### rtl/core/stamped_slot_queue_two_classes.sv
`timescale 1ns / 1ps

// Stamped slot queue with two classes.
// cmd carries one item per beat: kind 0 adds (writer_id, request_no) to
// the lowest free slot with the next running stamp; kind 1 takes the oldest
// element whose request number parity equals reader_class and frees its slot.
// result carries one beat per item: status, the taken element and the slot.
// Every item scans the whole slot table, one slot a cycle through the stamp
// and element memories (one read port each, registered read).
// Each item passes through the scan, last and finish states in turn; the
// next cmd beat is taken only once the previous item has committed.
// The result register holds a finished beat while the receiver stalls; the
// next item is accepted and scanned meanwhile and waits at commit until the
// register is free.
// Reset (rst_n, asynchronous, active low) empties every slot at once through
// per-slot occupancy flags and zeroes the stamp counter; no clearing pass.
module stamped_slot_queue_two_classes
    import ssq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ssq_cmd_if.sink   cmd,
    ssq_res_if.source result
);

    ssq_rd_req_t  rd_req;
    ssq_rd_data_t rd_data;
    ssq_wr_t      wr;

    // Sequencer, stamp counter and result register
    ssq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .result  (result),
        .rd_req  (rd_req),
        .rd_data (rd_data),
        .wr      (wr)
    );

    // Slot table
    ssq_slot_mem u_slot_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_req  (rd_req),
        .rd_data (rd_data),
        .wr      (wr)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ssq_pkg::*;

    localparam int RANDOM_ITEMS  = 1450;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 2 * (SLOTS + 3);
    localparam int CYCLE_LIMIT   = 400000;

    // One command beat as driven on cmd
    typedef struct packed {
        logic             kind;
        logic             cls;
        logic [WID_W-1:0] wid;
        logic [REQ_W-1:0] req;
    } queue_cmd_t;

    // One result beat as predicted
    typedef struct packed {
        ssq_status_t       status;
        logic [WID_W-1:0]  wid;
        logic [REQ_W-1:0]  req;
        logic [SLOT_W-1:0] slot;
    } queue_result_t;

    // Receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    // Shadow slot table and the results it predicts, oldest first
    class slot_queue_board;
        logic [STAMP_W-1:0] held_stamp   [SLOTS];
        logic [WID_W-1:0]   held_writer  [SLOTS];
        logic [REQ_W-1:0]   held_request [SLOTS];
        logic [STAMP_W-1:0] last_stamp;
        queue_result_t      due_results[$];
        int mismatches;
        int checked;
        int adds;
        int takes;
        int full_refusals;
        int empty_takes;

        function new();
            foreach (held_stamp[i])
            begin
                held_stamp[i]   = '0;
                held_writer[i]  = '0;
                held_request[i] = '0;
            end
            last_stamp    = '0;
            mismatches    = 0;
            checked       = 0;
            adds          = 0;
            takes         = 0;
            full_refusals = 0;
            empty_takes   = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Apply one accepted command to the shadow table and queue its result
        function void note_command(queue_cmd_t c);
            queue_result_t r;
            int pick;
            r.status = STATUS_OK;
            r.wid    = '0;
            r.req    = '0;
            r.slot   = '0;
            pick     = -1;
            if (c.kind == KIND_ADD)
            begin
                adds++;
                // lowest free slot
                for (int i = 0; i < SLOTS && pick < 0; i++)
                    if (held_stamp[i] == '0)
                        pick = i;
                if (pick < 0)
                begin
                    r.status = STATUS_FAIL;
                    full_refusals++;
                end
                else if (last_stamp == STAMP_MAX)
                    r.status = STATUS_EXHAUSTED;
                else
                begin
                    last_stamp          = last_stamp + 1'b1;
                    held_stamp[pick]    = last_stamp;
                    held_writer[pick]   = c.wid;
                    held_request[pick]  = c.req;
                    r.slot              = SLOT_W'(pick);
                end
            end
            else
            begin
                takes++;
                // oldest occupied slot of the class; ties keep the lower index
                for (int i = 0; i < SLOTS; i++)
                    if (held_stamp[i] != '0 && held_request[i][0] == c.cls &&
                        (pick < 0 || held_stamp[i] < held_stamp[pick]))
                        pick = i;
                if (pick < 0)
                begin
                    r.status = STATUS_FAIL;
                    empty_takes++;
                end
                else
                begin
                    held_stamp[pick] = '0;
                    r.wid            = held_writer[pick];
                    r.req            = held_request[pick];
                    r.slot           = SLOT_W'(pick);
                end
            end
            due_results.push_back(r);
        endfunction

        // Compare one accepted result beat with the oldest prediction
        function void check_result(logic [1:0] st, logic [WID_W-1:0] wid,
                                   logic [REQ_W-1:0] req, logic [SLOT_W-1:0] slot);
            queue_result_t e;
            if (due_results.size() == 0)
            begin
                $error("result beat with nothing outstanding: status %0d slot %0d",
                       st, slot);
                mismatches++;
                return;
            end
            e = due_results.pop_front();
            checked++;
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                mismatches++;
            end
            if (wid !== e.wid)
            begin
                $error("out_writer_id: expected %0d, got %0d", e.wid, wid);
                mismatches++;
            end
            if (req !== e.req)
            begin
                $error("out_request_no: expected 0x%08h, got 0x%08h", e.req, req);
                mismatches++;
            end
            if (slot !== e.slot)
            begin
                $error("slot_used: expected %0d, got %0d", e.slot, slot);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic hold_request;

    slot_queue_board board;

    ssq_cmd_if cmd_ch ();
    ssq_res_if res_ch ();

    stamped_slot_queue_two_classes u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch.sink),
        .result (res_ch.source)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[stamped_slot_queue_two_classes] ERROR");
        $finish;
    end

    // Result beats checked at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            board.check_result(res_ch.status, res_ch.out_writer_id,
                               res_ch.out_request_no, res_ch.slot_used);
    end

    // Receiver: changing stall patterns, plus one long hold-off on request
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       rx_tick;
        mode      = RX_ALWAYS;
        mode_left = 0;
        rx_tick   = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (hold_request)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 250);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:   res_ch.ready <= 1'b1;
                    RX_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   res_ch.ready <= ($urandom_range(0, 4) == 0);
                    default:     res_ch.ready <= (rx_tick % 4 == 0);
                endcase
            end
        end
    end

    // Offer one beat at the falling edge and hold it until taken
    task automatic drive_cmd(input queue_cmd_t c);
        @(negedge clk);
        cmd_ch.valid        <= 1'b1;
        cmd_ch.kind         <= c.kind;
        cmd_ch.reader_class <= c.cls;
        cmd_ch.writer_id    <= c.wid;
        cmd_ch.request_no   <= c.req;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        board.note_command(c);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        idle_for(1);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic queue_cmd_t random_cmd(input int add_pct);
        queue_cmd_t c;
        c.kind = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_TAKE;
        c.cls  = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       c.wid = '0;
            1:       c.wid = '1;
            default: c.wid = WID_W'($urandom_range(0, 63));
        endcase
        case ($urandom_range(0, 9))
            0:       c.req = '0;
            1:       c.req = '1;
            default: c.req = REQ_W'($urandom());
        endcase
        return c;
    endfunction

    // Stimulus
    initial
    begin
        logic [REQ_W-1:0] fill_req;
        logic [WID_W-1:0] fill_wid;
        int sent;
        int burst;
        int add_pct;
        int next_phase;
        bit hold_done;
        bit drain_done;

        board        = new();
        hold_request = 1'b0;
        rst_n        = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.kind         = KIND_ADD;
        cmd_ch.reader_class = 1'b0;
        cmd_ch.writer_id    = '0;
        cmd_ch.request_no   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Takes from an empty table, both classes
        drive_cmd('{KIND_TAKE, 1'b0, {WID_W{1'b1}}, {REQ_W{1'b1}}});
        drive_cmd('{KIND_TAKE, 1'b1, {WID_W{1'b0}}, {REQ_W{1'b0}}});

        // Fill every slot, alternating classes, field extremes first
        for (int i = 0; i < SLOTS; i++)
        begin
            fill_req    = REQ_W'($urandom());
            fill_req[0] = i[0];
            fill_wid    = WID_W'(i * 4 + 3);
            if (i == 0)
            begin
                fill_req = '0;
                fill_wid = '0;
            end
            else if (i == 1)
            begin
                fill_req = '1;
                fill_wid = '1;
            end
            drive_cmd('{KIND_ADD, i[0], fill_wid, fill_req});
        end

        // Add to a full table, then FIFO takes per class and reuse of a freed slot
        drive_cmd('{KIND_ADD, 1'b1, {WID_W{1'b1}}, {REQ_W{1'b1}}});
        drive_cmd('{KIND_TAKE, 1'b0, 6'd0, 31'd0});
        drive_cmd('{KIND_TAKE, 1'b1, 6'd0, 31'd0});
        drive_cmd('{KIND_TAKE, 1'b0, 6'd0, 31'd0});
        drive_cmd('{KIND_ADD, 1'b0, 6'd42, 31'd7});
        drive_cmd('{KIND_TAKE, 1'b1, 6'd0, 31'd0});
        wait_drained();

        // Random bursts with phases of add-heavy, balanced and take-heavy mix
        sent       = 0;
        add_pct    = 50;
        next_phase = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= next_phase)
            begin
                case ($urandom_range(0, 2))
                    0:       add_pct = 85;
                    1:       add_pct = 50;
                    default: add_pct = 20;
                endcase
                next_phase = sent + $urandom_range(60, 160);
            end
            // receiver holds off while the sender keeps offering
            if (!hold_done && sent >= 400)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && sent >= 900)
            begin
                wait_drained();
                drain_done = 1'b1;
            end
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++)
            begin
                drive_cmd(random_cmd(add_pct));
                sent++;
            end
            idle_for(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d adds (%0d refused on a full table) and %0d takes (%0d empty)",
                 board.adds, board.full_refusals, board.takes, board.empty_takes);
        $display("%0d result beats checked, %0d field mismatches",
                 board.checked, board.mismatches);
        if (board.pending() != 0)
            $error("%0d predicted results never arrived", board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[stamped_slot_queue_two_classes] OK");
        else
            $display("[stamped_slot_queue_two_classes] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/ssq_pkg.sv
rtl/core/ssq_chan_if.sv
rtl/core/ssq_slot_mem.sv
rtl/core/ssq_ctrl.sv
rtl/core/stamped_slot_queue_two_classes.sv
sim/tb_top.sv
